// ----- design/atrp_pkg.sv -----
// ============================================================================
// Accelerometer tilt package
// Shared constants and the CORDIC arctangent table.
// ============================================================================
package atrp_pkg;

   // Number of entries in the arctangent table.
   localparam int unsigned TabLen = 24;

   // Angle limit in hundredths of a degree.
   localparam logic [14:0] LIMIT_CD = 15'd9000;

   // 18000/pi in Q16, used to turn Q30 radians into centidegrees.
   localparam logic [28:0] DEG_K = 29'd375493621;

   // Reciprocal of ten in Q24, rounded up.
   localparam logic [21:0] RECIP10 = 22'd1677722;

   // Milli-g per count, times ten.
   localparam logic [20:0] SCALE39 = 21'd39;

   // Arctangent of 2^-idx in Q30 radians.
   function automatic logic [31:0] atan_q30(input int unsigned idx);
      logic [31:0] val;
      unique case (idx)
         0:  val = 32'd843314856;
         1:  val = 32'd497837829;
         2:  val = 32'd263043836;
         3:  val = 32'd133525158;
         4:  val = 32'd67021686;
         5:  val = 32'd33543515;
         6:  val = 32'd16775850;
         7:  val = 32'd8388437;
         8:  val = 32'd4194282;
         9:  val = 32'd2097149;
         10: val = 32'd1048575;
         11: val = 32'd524287;
         12: val = 32'd262143;
         13: val = 32'd131071;
         14: val = 32'd65535;
         15: val = 32'd32767;
         16: val = 32'd16383;
         17: val = 32'd8191;
         18: val = 32'd4095;
         19: val = 32'd2047;
         20: val = 32'd1023;
         21: val = 32'd511;
         22: val = 32'd255;
         23: val = 32'd127;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

// ----- design/atrp_prep.sv -----
// ============================================================================
// Tilt front end
// Sign extension, squares, denominators and milli-g scaling in two stages.
// ============================================================================
module atrp_prep #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [15:0]         accel_x,
   input  logic [15:0]         accel_y,
   input  logic [15:0]         accel_z,
   output logic                out_valid,
   output logic [31:0]         den_roll,
   output logic [31:0]         den_pitch,
   output logic signed [16:0]  num_roll,
   output logic signed [16:0]  num_pitch,
   output logic signed [17:0]  milli_x,
   output logic signed [17:0]  milli_y,
   output logic signed [17:0]  milli_z
);

   logic signed [16:0] axis [3];
   logic signed [33:0] sq [3];
   logic [16:0]        mag [3];

   logic               v1_ff;
   logic [30:0]        sq_ff [3];
   logic [30:0]        sq_in [3];
   logic [20:0]        scaled_ff [3];
   logic [20:0]        scaled_in [3];
   logic               neg_ff [3];
   logic               neg_in [3];
   logic signed [16:0] num_r1_ff, num_p1_ff;

   logic               v2_ff;
   logic [31:0]        den_r_ff, den_p_ff;
   logic signed [16:0] num_r2_ff, num_p2_ff;
   logic signed [17:0] milli_ff [3];
   logic signed [17:0] milli_in [3];
   logic [42:0]        prod [3];
   logic [16:0]        quot [3];

   always_comb begin
      axis[0] = 17'(signed'(accel_x[SAMPLE_BITS-1:0]));
      axis[1] = 17'(signed'(accel_y[SAMPLE_BITS-1:0]));
      axis[2] = 17'(signed'(accel_z[SAMPLE_BITS-1:0]));
      for (int i = 0; i < 3; i++) begin
         sq[i]        = axis[i] * axis[i];
         sq_in[i]     = sq[i][30:0];
         neg_in[i]    = axis[i][16];
         mag[i]       = axis[i][16] ? 17'(-axis[i]) : 17'(axis[i]);
         scaled_in[i] = 21'(mag[i]) * atrp_pkg::SCALE39 + 21'd5;
      end
   end

   // Division by ten through a Q24 reciprocal; exact below 2^22.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i]     = 43'(scaled_ff[i]) * 43'(atrp_pkg::RECIP10);
         quot[i]     = prod[i][40:24];
         milli_in[i] = neg_ff[i] ? -18'(signed'({1'b0, quot[i]}))
                                 : 18'(signed'({1'b0, quot[i]}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i]     <= sq_in[i];
            scaled_ff[i] <= scaled_in[i];
            neg_ff[i]    <= neg_in[i];
            milli_ff[i]  <= milli_in[i];
         end
         num_r1_ff <= -axis[1];
         num_p1_ff <= -axis[0];
         num_r2_ff <= num_r1_ff;
         num_p2_ff <= num_p1_ff;
         den_r_ff  <= 32'(sq_ff[0]) + 32'(sq_ff[2]);
         den_p_ff  <= 32'(sq_ff[1]) + 32'(sq_ff[2]);
      end
   end

   assign out_valid = v2_ff;
   assign den_roll  = den_r_ff;
   assign den_pitch = den_p_ff;
   assign num_roll  = num_r2_ff;
   assign num_pitch = num_p2_ff;
   assign milli_x   = milli_ff[0];
   assign milli_y   = milli_ff[1];
   assign milli_z   = milli_ff[2];

endmodule

// ----- design/atrp_isqrt.sv -----
// ============================================================================
// Pipelined square root
// Integer square root of den * 2^30, one result bit per stage.
// ============================================================================
module atrp_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [31:0]       in_den,
   input  logic signed [16:0] in_num,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [30:0]       out_root,
   output logic signed [16:0] out_num,
   output logic [SIDE_W-1:0] out_side
);

   localparam int Stages = 31;

   logic              valid_ff [Stages];
   logic [61:0]       rad_ff   [Stages];
   logic [33:0]       rem_ff   [Stages];
   logic [30:0]       root_ff  [Stages];
   logic signed [16:0] num_ff  [Stages];
   logic [SIDE_W-1:0] side_ff  [Stages];

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic              vi;
      logic [61:0]       radi;
      logic [33:0]       remi;
      logic [30:0]       rooti;
      logic signed [16:0] numi;
      logic [SIDE_W-1:0] sidei;
      logic [33:0]       rem4;
      logic [33:0]       trial;

      if (s == 0) begin : g_first
         assign vi    = in_valid;
         assign radi  = {in_den, 30'd0};
         assign remi  = '0;
         assign rooti = '0;
         assign numi  = in_num;
         assign sidei = in_side;
      end else begin : g_next
         assign vi    = valid_ff[s-1];
         assign radi  = rad_ff[s-1];
         assign remi  = rem_ff[s-1];
         assign rooti = root_ff[s-1];
         assign numi  = num_ff[s-1];
         assign sidei = side_ff[s-1];
      end

      assign rem4  = {remi[31:0], radi[61:60]};
      assign trial = {1'b0, rooti, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= vi;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= {radi[59:0], 2'b00};
            num_ff[s]  <= numi;
            side_ff[s] <= sidei;
            if (rem4 >= trial) begin
               rem_ff[s]  <= rem4 - trial;
               root_ff[s] <= {rooti[29:0], 1'b1};
            end else begin
               rem_ff[s]  <= rem4;
               root_ff[s] <= {rooti[29:0], 1'b0};
            end
         end
      end
   end

   assign out_valid = valid_ff[Stages-1];
   assign out_root  = root_ff[Stages-1];
   assign out_num   = num_ff[Stages-1];
   assign out_side  = side_ff[Stages-1];

endmodule

// ----- design/atrp_cordic.sv -----
// ============================================================================
// Pipelined vectoring CORDIC
// Arctangent in Q30 radians, then conversion to clamped centidegrees.
// ============================================================================
module atrp_cordic #(
   parameter int STEPS  = 16,
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [30:0]        in_root,
   input  logic signed [16:0] in_num,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output logic signed [14:0] out_angle,
   output logic               out_undef,
   output logic [SIDE_W-1:0]  out_side
);

   logic               valid_ff [STEPS];
   logic signed [35:0] x_ff     [STEPS];
   logic signed [35:0] y_ff     [STEPS];
   logic signed [32:0] z_ff     [STEPS];
   logic               zden_ff  [STEPS];
   logic               nneg_ff  [STEPS];
   logic               nzero_ff [STEPS];
   logic [SIDE_W-1:0]  side_ff  [STEPS];

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      localparam logic signed [32:0] Ang = 33'(atrp_pkg::atan_q30(s));
      logic               vi;
      logic signed [35:0] xi, yi;
      logic signed [32:0] zi;
      logic               zdi, nni, nzi;
      logic [SIDE_W-1:0]  sidei;

      if (s == 0) begin : g_first
         assign vi    = in_valid;
         assign xi    = 36'(signed'({1'b0, in_root}));
         assign yi    = 36'(in_num) <<< 15;
         assign zi    = '0;
         assign zdi   = (in_root == '0);
         assign nni   = in_num[16];
         assign nzi   = (in_num == '0);
         assign sidei = in_side;
      end else begin : g_next
         assign vi    = valid_ff[s-1];
         assign xi    = x_ff[s-1];
         assign yi    = y_ff[s-1];
         assign zi    = z_ff[s-1];
         assign zdi   = zden_ff[s-1];
         assign nni   = nneg_ff[s-1];
         assign nzi   = nzero_ff[s-1];
         assign sidei = side_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= vi;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            zden_ff[s]  <= zdi;
            nneg_ff[s]  <= nni;
            nzero_ff[s] <= nzi;
            side_ff[s]  <= sidei;
            if (yi > 36'sd0) begin
               x_ff[s] <= xi + (yi >>> s);
               y_ff[s] <= yi - (xi >>> s);
               z_ff[s] <= zi + Ang;
            end else begin
               x_ff[s] <= xi - (yi >>> s);
               y_ff[s] <= yi + (xi >>> s);
               z_ff[s] <= zi - Ang;
            end
         end
      end
   end

   // Conversion stage one: magnitude times 18000/pi.
   logic signed [32:0] z_last;
   logic [31:0]        z_mag;
   logic               m_valid_ff;
   logic [60:0]        m_prod_ff;
   logic               m_neg_ff, m_zden_ff, m_nneg_ff, m_nzero_ff;
   logic [SIDE_W-1:0]  m_side_ff;

   assign z_last = z_ff[STEPS-1];
   assign z_mag  = z_last[32] ? 32'(-z_last) : 32'(z_last);

   // Conversion stage two: round, clamp and resolve the zero denominator.
   logic [60:0]        rounded;
   logic [14:0]        cd;
   logic [14:0]        cd_lim;
   logic signed [14:0] angle_in;
   logic               undef_in;
   logic               o_valid_ff;
   logic signed [14:0] o_angle_ff;
   logic               o_undef_ff;
   logic [SIDE_W-1:0]  o_side_ff;

   always_comb begin
      rounded  = m_prod_ff + (61'd1 << 45);
      cd       = rounded[60:46];
      cd_lim   = (cd > atrp_pkg::LIMIT_CD) ? atrp_pkg::LIMIT_CD : cd;
      undef_in = 1'b0;
      priority if (m_zden_ff && m_nzero_ff) begin
         angle_in = '0;
         undef_in = 1'b1;
      end else if (m_zden_ff) begin
         angle_in = m_nneg_ff ? -signed'(atrp_pkg::LIMIT_CD)
                              : signed'(atrp_pkg::LIMIT_CD);
      end else begin
         angle_in = m_neg_ff ? -signed'(cd_lim) : signed'(cd_lim);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= valid_ff[STEPS-1];
         o_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_prod_ff  <= 61'(z_mag) * 61'(atrp_pkg::DEG_K);
         m_neg_ff   <= z_last[32];
         m_zden_ff  <= zden_ff[STEPS-1];
         m_nneg_ff  <= nneg_ff[STEPS-1];
         m_nzero_ff <= nzero_ff[STEPS-1];
         m_side_ff  <= side_ff[STEPS-1];
         o_angle_ff <= angle_in;
         o_undef_ff <= undef_in;
         o_side_ff  <= m_side_ff;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_angle = o_angle_ff;
   assign out_undef = o_undef_ff;
   assign out_side  = o_side_ff;

endmodule

// ----- design/accel_tilt_roll_pitch_unit.sv -----
// From an accepted request to its response the data passes through 2 front-end
// stages, 31 square-root stages, one stage per CORDIC rotation and 2 angle-conversion
// stages.
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds while a response waits unaccepted at the output register.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
// ============================================================================
// Accelerometer tilt unit
// Converts a three-axis sample to milli-g and computes roll and pitch angles.
// ============================================================================
module accel_tilt_roll_pitch_unit #(
   parameter int SAMPLE_BITS  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // x_milli_g, y_milli_g, z_milli_g, roll_centideg,
                                    // pitch_centideg, zero fill (lowest first)
   output logic [0:0]  rsp_tuser    // angle_undefined
);

   // The table holds 24 rotations; more steps behave as 24.
   localparam int Steps = (CORDIC_STEPS > atrp_pkg::TabLen) ? atrp_pkg::TabLen
                                                            : CORDIC_STEPS;

   // The pipeline moves as one whenever the output register is empty or is
   // being read in this cycle.
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic               p_valid;
   logic [31:0]        den_roll, den_pitch;
   logic signed [16:0] num_roll, num_pitch;
   logic signed [17:0] milli_x, milli_y, milli_z;

   atrp_prep #(.SAMPLE_BITS(SAMPLE_BITS)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .accel_x   (req_tdata[15:0]),
      .accel_y   (req_tdata[31:16]),
      .accel_z   (req_tdata[47:32]),
      .out_valid (p_valid),
      .den_roll  (den_roll),
      .den_pitch (den_pitch),
      .num_roll  (num_roll),
      .num_pitch (num_pitch),
      .milli_x   (milli_x),
      .milli_y   (milli_y),
      .milli_z   (milli_z)
   );

   // The roll lane carries the X and Y milli-g values, the pitch lane carries Z.
   logic               sr_valid, sp_valid;
   logic [30:0]        root_roll, root_pitch;
   logic signed [16:0] sr_num, sp_num;
   logic [35:0]        sr_side;
   logic [17:0]        sp_side;

   atrp_isqrt #(.SIDE_W(36)) u_sqrt_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid),
      .in_den    (den_roll),
      .in_num    (num_roll),
      .in_side   ({milli_y, milli_x}),
      .out_valid (sr_valid),
      .out_root  (root_roll),
      .out_num   (sr_num),
      .out_side  (sr_side)
   );

   atrp_isqrt #(.SIDE_W(18)) u_sqrt_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p_valid),
      .in_den    (den_pitch),
      .in_num    (num_pitch),
      .in_side   (milli_z),
      .out_valid (sp_valid),
      .out_root  (root_pitch),
      .out_num   (sp_num),
      .out_side  (sp_side)
   );

   logic               cr_valid, cp_valid;
   logic signed [14:0] roll, pitch;
   logic               undef_roll, undef_pitch;
   logic [35:0]        cr_side;
   logic [17:0]        cp_side;

   atrp_cordic #(.STEPS(Steps), .SIDE_W(36)) u_cordic_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sr_valid),
      .in_root   (root_roll),
      .in_num    (sr_num),
      .in_side   (sr_side),
      .out_valid (cr_valid),
      .out_angle (roll),
      .out_undef (undef_roll),
      .out_side  (cr_side)
   );

   atrp_cordic #(.STEPS(Steps), .SIDE_W(18)) u_cordic_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sp_valid),
      .in_root   (root_pitch),
      .in_num    (sp_num),
      .in_side   (sp_side),
      .out_valid (cp_valid),
      .out_angle (pitch),
      .out_undef (undef_pitch),
      .out_side  (cp_side)
   );

   // The last conversion stage of each CORDIC is the output register.
   assign rsp_tvalid   = cr_valid;
   assign rsp_tdata    = {4'd0, pitch, roll, cp_side, cr_side};
   assign rsp_tuser[0] = undef_roll | undef_pitch;

   // Both lanes run in lockstep, so their valid bits always agree.
   a_lanes_aligned : assert property (@(posedge clock) disable iff (reset)
      cr_valid == cp_valid)
      else $error("roll and pitch lanes out of step");

   // An undefined angle is reported as zero.
   a_undef_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (roll == 15'sd0 || pitch == 15'sd0))
      else $error("undefined angle is not zero");

   a_roll_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (roll <= 15'sd9000 && roll >= -15'sd9000))
      else $error("roll out of range");

   a_pitch_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pitch <= 15'sd9000 && pitch >= -15'sd9000))
      else $error("pitch out of range");

endmodule
